// File: rtl/core/pesp_pkg.sv
// ----------------------------------------------------------------------------
// pesp_pkg
// Shared types and constants for the PES header parser.
// ----------------------------------------------------------------------------
package pesp_pkg;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'd0,
    PH_ID      = 5'd1,
    PH_LENHI   = 5'd2,
    PH_LENLO   = 5'd3,
    PH_SKIP    = 5'd4,
    PH_PAYLOAD = 5'd5,
    PH_FLAGS1  = 5'd6,
    PH_FLAGS2  = 5'd7,
    PH_HDRLEN  = 5'd8,
    PH_PTS     = 5'd9,
    PH_DTS     = 5'd10,
    PH_ESCR    = 5'd11,
    PH_RATE    = 5'd12,
    PH_TRICK   = 5'd13,
    PH_COPY    = 5'd14,
    PH_CRC     = 5'd15,
    PH_EXTF    = 5'd16,
    PH_PRIV    = 5'd17,
    PH_PACKLEN = 5'd18,
    PH_PACK    = 5'd19,
    PH_SEQ     = 5'd20,
    PH_PSTD    = 5'd21,
    PH_EXTLEN  = 5'd22,
    PH_EXTB    = 5'd23,
    PH_STUFF   = 5'd24
  } phase_t;

  localparam logic [3:0] ERR_OK        = 4'd0;
  localparam logic [3:0] ERR_BAD_ID    = 4'd1;
  localparam logic [3:0] ERR_MARKER10  = 4'd2;
  localparam logic [3:0] ERR_PTSDTS    = 4'd3;
  localparam logic [3:0] ERR_TSTAMP    = 4'd4;
  localparam logic [3:0] ERR_ESCR      = 4'd5;
  localparam logic [3:0] ERR_RATE      = 4'd6;
  localparam logic [3:0] ERR_HDR_OVER  = 4'd7;
  localparam logic [3:0] ERR_PKT_OVER  = 4'd8;

  localparam logic [2:0] ADDR_DETAIL = 3'd0;

  function automatic logic [4:0] phase_kind(input phase_t p);
    case (p)
      PH_LENHI, PH_LENLO:   phase_kind = 5'd1;
      PH_SKIP, PH_PAYLOAD:  phase_kind = 5'd19;
      PH_FLAGS1:            phase_kind = 5'd2;
      PH_FLAGS2:            phase_kind = 5'd3;
      PH_HDRLEN, PH_STUFF:  phase_kind = 5'd4;
      PH_PTS:               phase_kind = 5'd5;
      PH_DTS:               phase_kind = 5'd6;
      PH_ESCR:              phase_kind = 5'd7;
      PH_RATE:              phase_kind = 5'd8;
      PH_TRICK:             phase_kind = 5'd9;
      PH_COPY:              phase_kind = 5'd10;
      PH_CRC:               phase_kind = 5'd11;
      PH_EXTF:              phase_kind = 5'd12;
      PH_PRIV:              phase_kind = 5'd13;
      PH_PACKLEN, PH_PACK:  phase_kind = 5'd14;
      PH_SEQ:               phase_kind = 5'd15;
      PH_PSTD:              phase_kind = 5'd16;
      PH_EXTLEN:            phase_kind = 5'd17;
      PH_EXTB:              phase_kind = 5'd18;
      default:              phase_kind = 5'd0;
    endcase
  endfunction

endpackage

// File: rtl/core/pes_header_parser_top.sv
// ----------------------------------------------------------------------------
// pes_header_parser_top
// An accepted byte's result is written into the output register in the next cycle.
// Throughput: one byte per cycle; the whole parse step sits between the phase
// registers and the output register, and input stalls only when the output
// register holds a result that the sink is not taking in that cycle.
// Reset: rst (synchronous) returns to start-code hunt, detail_enable to 1.
// ----------------------------------------------------------------------------
module pes_header_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [41:0] value, [45:42] error_code, zeros
  output logic [4:0]  m_tuser,   // [4:0] kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pesp_pkg::*;

  logic        detail_enable;
  phase_t      parse_phase, parse_phase_next;
  logic [1:0]  zero_run, zero_run_next;
  logic [7:0]  stream_number, stream_number_next;
  logic [15:0] pkt_left, pkt_left_next;
  logic [7:0]  hdr_left, hdr_left_next;
  logic [15:0] opt_flags, opt_flags_next;
  logic [47:0] acc, acc_next;
  logic [4:0]  byte_cnt, byte_cnt_next;

  logic        res_valid;
  logic [4:0]  res_kind;
  logic [41:0] res_value;
  logic [3:0]  res_err;
  logic        res_last;

  logic        accept;

  assign pready   = 1'b1;
  assign prdata   = (paddr == ADDR_DETAIL) ? {31'd0, detail_enable} : 32'd0;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  function automatic logic present(input phase_t q, input logic [15:0] f);
    logic ext;
    ext = f[0];
    case (q)
      PH_PTS:     present = f[7];
      PH_DTS:     present = f[7] && f[6];
      PH_ESCR:    present = f[5];
      PH_RATE:    present = f[4];
      PH_TRICK:   present = f[3];
      PH_COPY:    present = f[2];
      PH_CRC:     present = f[1];
      PH_EXTF:    present = ext;
      PH_PRIV:    present = ext && f[15];
      PH_PACKLEN: present = ext && f[14];
      PH_SEQ:     present = ext && f[13];
      PH_PSTD:    present = ext && f[12];
      PH_EXTLEN:  present = ext && f[8];
      default:    present = 1'b0;
    endcase
  endfunction

  function automatic logic [32:0] tstamp(input logic [47:0] a);
    tstamp = {a[35:33], a[31:17], a[15:1]};
  endfunction

  // next-element lookup, over the flags and lengths as they stand after the byte
  logic        adv_en;
  phase_t      adv_from;
  phase_t      adv_phase;
  logic        adv_hunt;

  always_comb begin
    adv_phase = PH_STUFF;
    adv_hunt  = 1'b0;
    for (int q = int'(PH_STUFF) - 1; q >= int'(PH_PTS); q--) begin
      if (q > int'(adv_from) && present(phase_t'(5'(q)), opt_flags_next))
        adv_phase = phase_t'(5'(q));
    end
    if (adv_phase == PH_STUFF) begin
      if (hdr_left_next != 8'd0)      adv_phase = PH_STUFF;
      else if (pkt_left_next != 16'd0) adv_phase = PH_PAYLOAD;
      else begin
        adv_phase = PH_HUNT;
        adv_hunt  = 1'b1;
      end
    end
  end

  logic        emit;
  logic [4:0]  e_kind;
  logic [41:0] e_value;
  logic [3:0]  e_err;
  logic        e_last;
  logic        e_fail;
  logic        e_done;
  logic [4:0]  kind_now;
  logic [47:0] a_sh;
  logic [4:0]  cnt_inc;
  logic [7:0]  b;
  logic [7:0]  left_b;
  logic [32:0] escr_clk;
  logic [2:0]  ctl;
  phase_t      ph_pre;
  phase_t      fin_phase;
  logic [15:0] pkt_dec;

  always_comb begin
    b        = s_tdata;
    kind_now = phase_kind(parse_phase);
    a_sh     = {acc[39:0], b};
    cnt_inc  = byte_cnt + 5'd1;
    left_b   = a_sh[15:8];
    escr_clk = {a_sh[45:43], a_sh[41:27], a_sh[25:11]};
    ctl      = b[7:5];
    pkt_dec  = (pkt_left != 16'd0) ? pkt_left - 16'd1 : 16'd0;

    ph_pre             = parse_phase;
    zero_run_next      = zero_run;
    stream_number_next = stream_number;
    pkt_left_next      = pkt_left;
    hdr_left_next      = hdr_left;
    opt_flags_next     = opt_flags;
    acc_next           = acc;
    byte_cnt_next      = byte_cnt;
    adv_en   = 1'b0;
    adv_from = parse_phase;
    emit     = 1'b0;
    e_kind   = kind_now;
    e_value  = 42'(b);
    e_err    = ERR_OK;
    e_last   = 1'b0;
    e_fail   = 1'b0;
    e_done   = 1'b0;

    unique case (parse_phase)
      PH_HUNT: begin
        if (b == 8'd1 && zero_run == 2'd2) begin
          ph_pre = PH_ID;
          zero_run_next = 2'd0;
        end else if (b == 8'd0) begin
          if (zero_run < 2'd2) zero_run_next = zero_run + 2'd1;
        end else zero_run_next = 2'd0;
      end
      PH_ID: begin
        stream_number_next = b;
        emit = 1'b1;
        e_kind = 5'd0;
        if (b < 8'hBC) begin
          e_fail = 1'b1;
          e_err  = ERR_BAD_ID;
        end else ph_pre = PH_LENHI;
      end
      PH_LENHI: begin
        acc_next = 48'(b);
        ph_pre = PH_LENLO;
      end
      PH_LENLO: begin
        pkt_left_next  = {acc[7:0], b};
        hdr_left_next  = 8'd0;
        opt_flags_next = 16'd0;
        acc_next       = 48'd0;
        byte_cnt_next  = 5'd0;
        emit    = 1'b1;
        e_kind  = 5'd1;
        e_value = 42'({acc[7:0], b});
        if (!detail_enable) begin
          ph_pre = (pkt_left_next != 16'd0) ? PH_SKIP : PH_HUNT;
          e_last = 1'b1;
          if (pkt_left_next == 16'd0) zero_run_next = 2'd0;
        end else if (stream_number == 8'hBC || stream_number == 8'hBE ||
                     stream_number == 8'hBF || stream_number == 8'hF0 ||
                     stream_number == 8'hF1 || stream_number == 8'hF2 ||
                     stream_number == 8'hF8 || stream_number == 8'hFF) begin
          ph_pre = (pkt_left_next != 16'd0) ? PH_PAYLOAD : PH_HUNT;
          e_last = (pkt_left_next == 16'd0);
          if (pkt_left_next == 16'd0) zero_run_next = 2'd0;
        end else ph_pre = PH_FLAGS1;
      end
      PH_SKIP, PH_PAYLOAD: begin
        pkt_left_next = pkt_dec;
        if (pkt_dec == 16'd0) begin
          ph_pre = PH_HUNT;
          zero_run_next = 2'd0;
        end
        if (parse_phase == PH_PAYLOAD) begin
          emit   = 1'b1;
          e_kind = 5'd19;
          e_last = (pkt_dec == 16'd0);
        end
      end
      PH_FLAGS1, PH_FLAGS2, PH_HDRLEN: begin
        emit = 1'b1;
        if (pkt_left == 16'd0) begin
          e_fail = 1'b1;
          e_err  = ERR_PKT_OVER;
        end else begin
          pkt_left_next = pkt_left - 16'd1;
          if (parse_phase == PH_FLAGS1) begin
            if (b[7:6] != 2'b10) begin
              e_fail = 1'b1;
              e_err  = ERR_MARKER10;
            end else ph_pre = PH_FLAGS2;
          end else if (parse_phase == PH_FLAGS2) begin
            if (b[7:6] == 2'b01) begin
              e_fail = 1'b1;
              e_err  = ERR_PTSDTS;
            end else begin
              opt_flags_next = {8'd0, b};
              ph_pre = PH_HDRLEN;
            end
          end else begin
            if (16'(b) > pkt_left_next) begin
              e_fail = 1'b1;
              e_err  = ERR_PKT_OVER;
            end else begin
              hdr_left_next = b;
              e_done = 1'b1;
            end
          end
        end
      end
      PH_PTS, PH_DTS, PH_ESCR, PH_RATE, PH_TRICK, PH_COPY, PH_CRC, PH_EXTF,
      PH_PRIV, PH_PACKLEN, PH_PACK, PH_SEQ, PH_PSTD, PH_EXTLEN, PH_EXTB,
      PH_STUFF: begin
        if (hdr_left == 8'd0) begin
          emit   = 1'b1;
          e_fail = 1'b1;
          e_err  = ERR_HDR_OVER;
        end else begin
          hdr_left_next = hdr_left - 8'd1;
          pkt_left_next = pkt_dec;
          acc_next      = a_sh;
          byte_cnt_next = cnt_inc;
          case (parse_phase)
            PH_PTS, PH_DTS: begin
              if (cnt_inc >= 5'd5) begin
                emit = 1'b1;
                if (a_sh[39:36] != ((parse_phase == PH_PTS) ?
                                    {2'b00, opt_flags[7:6]} : 4'd1) ||
                    !a_sh[32] || !a_sh[16] || !a_sh[0]) begin
                  e_fail = 1'b1;
                  e_err  = ERR_TSTAMP;
                end else begin
                  e_value = 42'(tstamp(a_sh));
                  e_done  = 1'b1;
                end
              end
            end
            PH_ESCR: begin
              if (cnt_inc >= 5'd6) begin
                emit = 1'b1;
                if (!a_sh[42] || !a_sh[26] || !a_sh[10] || !a_sh[0]) begin
                  e_fail = 1'b1;
                  e_err  = ERR_ESCR;
                end else begin
                  e_value = {escr_clk, a_sh[9:1]};
                  e_done  = 1'b1;
                end
              end
            end
            PH_RATE: begin
              if (cnt_inc >= 5'd3) begin
                emit = 1'b1;
                if (!a_sh[23] || !a_sh[0]) begin
                  e_fail = 1'b1;
                  e_err  = ERR_RATE;
                end else begin
                  e_value = 42'(a_sh[22:1]);
                  e_done  = 1'b1;
                end
              end
            end
            PH_TRICK: begin
              emit = 1'b1;
              e_done = 1'b1;
              if (ctl == 3'd2)      e_value = 42'(b & 8'hF8);
              else if (ctl >= 3'd5) e_value = 42'(b & 8'hE0);
            end
            PH_COPY: begin
              emit = 1'b1;
              e_done = 1'b1;
              e_value = 42'(b & 8'h7F);
            end
            PH_CRC: begin
              if (cnt_inc >= 5'd2) begin
                emit = 1'b1;
                e_done = 1'b1;
                e_value = 42'(a_sh[15:0]);
              end
            end
            PH_EXTF: begin
              opt_flags_next = {b, opt_flags[7:0]};
              emit = 1'b1;
              e_done = 1'b1;
            end
            PH_PRIV: begin
              emit = 1'b1;
              if (cnt_inc >= 5'd16) e_done = 1'b1;
            end
            PH_PACKLEN: begin
              emit = 1'b1;
              if (b == 8'd0) begin
                e_done = 1'b1;
                adv_from = PH_PACK;
              end else begin
                ph_pre = PH_PACK;
                acc_next = 48'(b);
                byte_cnt_next = 5'd0;
              end
            end
            PH_EXTLEN: begin
              emit = 1'b1;
              e_value = 42'(b & 8'h7F);
              if (b[6:0] == 7'd0) begin
                e_done = 1'b1;
                adv_from = PH_EXTB;
              end else begin
                ph_pre = PH_EXTB;
                acc_next = 48'(b & 8'h7F);
                byte_cnt_next = 5'd0;
              end
            end
            PH_PACK, PH_EXTB: begin
              emit = 1'b1;
              if (left_b > 8'd1) begin
                acc_next = 48'(left_b - 8'd1);
                byte_cnt_next = 5'd0;
              end else e_done = 1'b1;
            end
            PH_SEQ: begin
              if (cnt_inc >= 5'd2) begin
                emit = 1'b1;
                e_done = 1'b1;
                e_value = 42'({a_sh[14:8], a_sh[6:0]});
              end
            end
            PH_PSTD: begin
              if (cnt_inc >= 5'd2) begin
                emit = 1'b1;
                e_done = 1'b1;
                e_value = 42'({a_sh[13:8], a_sh[7:0]});
              end
            end
            default: begin
              // stuffing: leave when the header is used up
              if (hdr_left_next == 8'd0) begin
                e_done = 1'b0;
                adv_en = 1'b1;
                adv_from = PH_STUFF;
              end
            end
          endcase
        end
      end
      default: begin
        ph_pre = PH_HUNT;
        zero_run_next = 2'd0;
      end
    endcase

    if (e_done) adv_en = 1'b1;

    fin_phase = ph_pre;
    if (adv_en) begin
      acc_next      = 48'd0;
      byte_cnt_next = 5'd0;
      fin_phase     = adv_phase;
      if (adv_hunt) zero_run_next = 2'd0;
    end
    if (e_fail) begin
      fin_phase     = PH_HUNT;
      zero_run_next = 2'd0;
      e_last        = 1'b1;
      e_value       = 42'(b);
    end else if (e_done) begin
      e_last = (fin_phase == PH_HUNT) ||
               (fin_phase == PH_STUFF && pkt_left_next == 16'(hdr_left_next));
    end
    parse_phase_next = fin_phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      detail_enable <= 1'b1;
      parse_phase   <= PH_HUNT;
      zero_run      <= 2'd0;
      stream_number <= 8'd0;
      pkt_left      <= 16'd0;
      hdr_left      <= 8'd0;
      opt_flags     <= 16'd0;
      acc           <= 48'd0;
      byte_cnt      <= 5'd0;
      res_valid     <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_DETAIL)
        detail_enable <= pwdata[0];
      if (accept && emit) res_valid <= 1'b1;
      else if (m_tvalid && m_tready) res_valid <= 1'b0;
      if (accept) begin
        parse_phase   <= parse_phase_next;
        zero_run      <= zero_run_next;
        stream_number <= stream_number_next;
        pkt_left      <= pkt_left_next;
        hdr_left      <= hdr_left_next;
        opt_flags     <= opt_flags_next;
        acc           <= acc_next;
        byte_cnt      <= byte_cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_kind  <= e_kind;
      res_value <= e_value;
      res_err   <= e_err;
      res_last  <= e_last;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {2'b00, res_err, res_value};
  assign m_tuser  = res_kind;
  assign m_tlast  = res_last;

  // an error result always closes the packet
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[45:42] != ERR_OK) |-> m_tlast)
    else $error("error result without last");

  // a waiting result is not overwritten
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result lost under stall");

  // the hunt's zero counter never passes two
  assert property (@(posedge clk) disable iff (rst) zero_run != 2'd3)
    else $error("zero run overflow");

endmodule
